### sv/texel_format_to_rgba8888_core_defines.svh
// assertion macros shared by the checker of the texel format converter
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef TEXEL_FORMAT_TO_RGBA8888_CORE_DEFINES_SVH
`define TEXEL_FORMAT_TO_RGBA8888_CORE_DEFINES_SVH

// same-cycle implication
`define TFR_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tfr check failed: same-cycle rule");

// implication checked in the next cycle
`define TFR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tfr check failed: next-cycle rule");

`endif

### sv/tfr_pkg.sv
// shared types and constants of the texel format converter
// no dependencies
`default_nettype none

package tfr_pkg;

  localparam int unsigned MAX_SIZE_LOG2_DEF = 11;
  localparam int unsigned TEXEL_W           = 32;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned INDEX_W           = 22;
  localparam int unsigned FMT_W             = 4;
  localparam int unsigned LOG2_W            = 4;
  localparam int unsigned ASPECT_W          = 3;
  localparam int unsigned EXP_W             = LOG2_W + 1;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 4;

  typedef enum logic [FMT_W-1:0] {
    FMT_A8       = 4'd0,
    FMT_I8       = 4'd1,
    FMT_AI44     = 4'd2,
    FMT_RGB565   = 4'd3,
    FMT_ARGB1555 = 4'd4,
    FMT_AI88     = 4'd5,
    FMT_ARGB4444 = 4'd6,
    FMT_ARGB8888 = 4'd7
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT = 2'd0,
    CFG_LEVEL  = 2'd1,
    CFG_ASPECT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic        [LOG2_W-1:0]   size_log2;
    logic signed [ASPECT_W-1:0] aspect_log2;
  } level_cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               last;
  } pos_t;

endpackage

`default_nettype wire

### sv/tfr_convert.sv
// combinational texel format conversion into a 32-bit word, alpha on top
// depends on tfr_pkg
`default_nettype none

module tfr_convert (
  input  logic [tfr_pkg::FMT_W-1:0]   format_i,
  input  logic [tfr_pkg::TEXEL_W-1:0] texel_i,
  output logic [tfr_pkg::WORD_W-1:0]  word_o,
  output logic                        bad_o
);
  import tfr_pkg::*;

  logic [7:0] b;
  logic [3:0] ai_hi;
  logic [3:0] ai_lo;

  assign b     = texel_i[7:0];
  assign ai_hi = texel_i[7:4];
  assign ai_lo = texel_i[3:0];

  always_comb begin
    word_o = '0;
    bad_o  = 1'b0;
    unique case (format_i)
      FMT_A8:       word_o = {b, b, b, b};
      FMT_I8:       word_o = {8'hFF, b, b, b};
      FMT_AI44:     word_o = {ai_hi, ai_hi, ai_lo, ai_lo, ai_lo, ai_lo, ai_lo, ai_lo};
      FMT_RGB565:   word_o = {8'hFF, texel_i[4:0], 3'b000, texel_i[10:5], 2'b00,
                              texel_i[15:11], 3'b000};
      FMT_ARGB1555: word_o = {{8{texel_i[15]}}, texel_i[4:0], 3'b000,
                              texel_i[9:5], 3'b000, texel_i[14:10], 3'b000};
      FMT_AI88:     word_o = {texel_i[15:8], b, b, b};
      FMT_ARGB4444: word_o = {texel_i[15:12], 4'h0, texel_i[3:0], 4'h0,
                              texel_i[7:4], 4'h0, texel_i[11:8], 4'h0};
      FMT_ARGB8888: word_o = {texel_i[31:24], texel_i[7:0], texel_i[15:8],
                              texel_i[23:16]};
      default: begin
        word_o = '0;
        bad_o  = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/tfr_position.sv
// running texel position within the mip level, with last-texel detect
// depends on tfr_pkg
`default_nettype none

module tfr_position #(
  parameter int unsigned MAX_SIZE_LOG2 = tfr_pkg::MAX_SIZE_LOG2_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfr_pkg::level_cfg_t level_i,
  input  logic                advance_i,
  output tfr_pkg::pos_t       pos_o
);
  import tfr_pkg::*;

  logic [INDEX_W-1:0] counter_q, counter_d;
  logic [LOG2_W-1:0]  size_l;
  logic [LOG2_W-1:0]  aspect_mag;
  logic [LOG2_W-1:0]  small_l;
  logic [EXP_W-1:0]   exp_sum;
  logic [EXP_W-1:0]   exp_sat;
  logic [INDEX_W-1:0] last_pos;
  logic               is_last;

  always_comb begin
    size_l = (level_i.size_log2 > LOG2_W'(MAX_SIZE_LOG2)) ?
             LOG2_W'(MAX_SIZE_LOG2) : level_i.size_log2;
    // pattern 100 reads as a shift of four
    if (level_i.aspect_log2[ASPECT_W-1]) begin
      aspect_mag = LOG2_W'(unsigned'(ASPECT_W'(~level_i.aspect_log2 + ASPECT_W'(1))));
    end else begin
      aspect_mag = LOG2_W'(level_i.aspect_log2);
    end
    // smaller dimension clamps to one texel
    small_l = (aspect_mag > size_l) ? '0 : (size_l - aspect_mag);
    exp_sum = EXP_W'(size_l) + EXP_W'(small_l);
    exp_sat = (exp_sum > EXP_W'(INDEX_W)) ? EXP_W'(INDEX_W) : exp_sum;
    for (int i = 0; i < INDEX_W; i++) begin
      last_pos[i] = (EXP_W'(i) < exp_sat);
    end
    is_last   = (counter_q >= last_pos);
    counter_d = is_last ? '0 : (counter_q + INDEX_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
    end else if (advance_i) begin
      counter_q <= counter_d;
    end
  end

  assign pos_o.index = counter_q;
  assign pos_o.last  = is_last;

endmodule

`default_nettype wire

### sv/texel_format_to_rgba8888_core.sv
// top level of the texel format converter: config registers, input and result stages
// depends on tfr_pkg, tfr_convert and tfr_position
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in
//  in      | in_valid_i in_ready_o texel_in_i               | in
//  out     | out_valid_o out_ready_i rgba_word_o            | out
//          | texel_index_o last_texel_o format_unsupported_o|
//
// one request per cycle sustained while out_ready_i holds; an accepted texel reaches the output through
// the input register, then the result register, with conversion and position logic in between
// reset clears the configuration, the position counter and both valid flags
// a stalled result holds in the result register while the input register still takes one more
// the position counter advances when a texel moves into the result register
`default_nettype none

module texel_format_to_rgba8888_core #(
  parameter int unsigned MAX_SIZE_LOG2 = tfr_pkg::MAX_SIZE_LOG2_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tfr_pkg::TEXEL_W-1:0]    texel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tfr_pkg::WORD_W-1:0]     rgba_word_o,
  output logic [tfr_pkg::INDEX_W-1:0]    texel_index_o,
  output logic                           last_texel_o,
  output logic                           format_unsupported_o
);
  import tfr_pkg::*;

  logic [FMT_W-1:0]   format_q;
  level_cfg_t         level_q;

  logic               s1_valid_q;
  logic [TEXEL_W-1:0] s1_texel_q;
  logic               s1_move;

  logic               out_valid_q;
  logic [WORD_W-1:0]  word_q;
  logic [INDEX_W-1:0] index_q;
  logic               last_q;
  logic               bad_q;

  logic [WORD_W-1:0]  word_d;
  logic               bad_d;
  pos_t               pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= '0;
      level_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FORMAT: format_q            <= cfg_data_i[FMT_W-1:0];
        CFG_LEVEL:  level_q.size_log2   <= cfg_data_i[LOG2_W-1:0];
        CFG_ASPECT: level_q.aspect_log2 <= cfg_data_i[ASPECT_W-1:0];
        default: ;
      endcase
    end
  end

  // result register frees up when empty or being drained
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_texel_q <= texel_in_i;
    end
  end

  tfr_convert u_convert (
    .format_i (format_q),
    .texel_i  (s1_texel_q),
    .word_o   (word_d),
    .bad_o    (bad_d)
  );

  tfr_position #(
    .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
  ) u_position (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .level_i   (level_q),
    .advance_i (s1_move),
    .pos_o     (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      word_q  <= word_d;
      index_q <= pos.index;
      last_q  <= pos.last;
      bad_q   <= bad_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign rgba_word_o          = word_q;
  assign texel_index_o        = index_q;
  assign last_texel_o         = last_q;
  assign format_unsupported_o = bad_q;

endmodule

`default_nettype wire

### sv/tfr_checker.sv
// port-level checker for the texel format converter, bound to the top level
// depends on tfr_pkg and texel_format_to_rgba8888_core_defines.svh
`default_nettype none

`include "texel_format_to_rgba8888_core_defines.svh"

module tfr_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [tfr_pkg::WORD_W-1:0]  rgba_word_o,
  input  logic [tfr_pkg::INDEX_W-1:0] texel_index_o,
  input  logic                        last_texel_o,
  input  logic                        format_unsupported_o
);
  import tfr_pkg::*;

  logic               have_prev_q;
  logic [INDEX_W-1:0] exp_index_q;
  logic [INDEX_W-1:0] exp_index_d;

  // index after a last texel wraps, otherwise steps by one
  assign exp_index_d = last_texel_o ? '0 : (texel_index_o + INDEX_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      exp_index_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      have_prev_q <= 1'b1;
      exp_index_q <= exp_index_d;
    end
  end

  `TFR_ASSERT_NOW(a_index_seq, out_valid_o && have_prev_q, texel_index_o == exp_index_q)
  `TFR_ASSERT_NOW(a_bad_zero, out_valid_o && format_unsupported_o, rgba_word_o == '0)
  `TFR_ASSERT_NOW(a_top_is_last, out_valid_o && (&texel_index_o), last_texel_o)
  `TFR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind texel_format_to_rgba8888_core tfr_checker u_tfr_checker (.*);

`default_nettype wire
